// ===== hw/rtl/emb_pkg.sv =====
// ----------------------------------------------------------------------------
// emb_pkg
// Shared constants, types and helpers of the 3x3 emboss clamp filter.
// ----------------------------------------------------------------------------
package emb_pkg;

	localparam int MAX_WIDTH    = 2048;
	localparam int MAX_HEIGHT   = 2048;
	localparam int MAX_CHANNELS = 4;

	localparam int PIX_W = 8;
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);
	localparam int CH_W  = $clog2(MAX_CHANNELS);
	localparam int DIM_W = 12;
	localparam int NCH_W = 3;
	localparam int CFG_W = 12;

	localparam int LINE_DEPTH = MAX_WIDTH * MAX_CHANNELS;
	localparam int LINE_W     = 2 * PIX_W;

	localparam int MAX_RESULTS    = 3;
	localparam int RES_FIFO_DEPTH = 8;

	localparam logic [DIM_W-1:0] WIDTH_RST    = DIM_W'(640);
	localparam logic [DIM_W-1:0] HEIGHT_RST   = DIM_W'(480);
	localparam logic [NCH_W-1:0] CHANNELS_RST = NCH_W'(3);

	typedef enum logic [1:0] {
		CFG_WIDTH    = 2'd0,
		CFG_HEIGHT   = 2'd1,
		CFG_CHANNELS = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
		logic [NCH_W-1:0] nc;
	} geom_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_value;
		logic [ROW_W-1:0] out_row;
		logic [COL_W-1:0] out_column;
		logic [CH_W-1:0]  out_channel;
		logic             last_of_run;
		logic             end_of_frame;
	} res_t;

	typedef struct packed {
		logic [MAX_RESULTS-1:0] valid;
		res_t [MAX_RESULTS-1:0] item;
	} res_push_t;

	function automatic logic is_eof(input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c,
			input logic [CH_W-1:0] ch, input geom_t g);
		return ({1'b0, r} == g.h - DIM_W'(1)) && ({1'b0, c} == g.w - DIM_W'(1))
			&& ({1'b0, ch} == g.nc - NCH_W'(1));
	endfunction

endpackage

// ===== hw/rtl/emb_in_if.sv =====
// ----------------------------------------------------------------------------
// emb_in_if
// Input sample channel: valid/ready with one 8-bit sample per request.
// ----------------------------------------------------------------------------
interface emb_in_if;
	import emb_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

// ===== hw/rtl/emb_out_if.sv =====
// ----------------------------------------------------------------------------
// emb_out_if
// Result channel: valid/ready with one tagged filtered sample per request.
// ----------------------------------------------------------------------------
interface emb_out_if;
	import emb_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_value;
	logic [ROW_W-1:0] out_row;
	logic [COL_W-1:0] out_column;
	logic [CH_W-1:0]  out_channel;
	logic             last_of_run;
	logic             end_of_frame;

	modport source (output valid, output pixel_value, output out_row, output out_column,
		output out_channel, output last_of_run, output end_of_frame, input ready);
	modport sink (input valid, input pixel_value, input out_row, input out_column,
		input out_channel, input last_of_run, input end_of_frame, output ready);
endinterface

// ===== hw/rtl/emb_line_ram.sv =====
// ----------------------------------------------------------------------------
// emb_line_ram
// Simple dual-port RAM, one write and one registered read per cycle, with
// write-to-read bypass when both hit the same address.
// ----------------------------------------------------------------------------
module emb_line_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr)) begin
				rd_data <= wr_data;
			end else begin
				rd_data <= mem[rd_addr];
			end
		end
	end
endmodule

// ===== hw/rtl/emb_window.sv =====
// ----------------------------------------------------------------------------
// emb_window
// Per-channel 3x3 window columns, emboss kernel with clamp, and the up to
// three tagged results produced by one sample.
// ----------------------------------------------------------------------------
module emb_window (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     upd,
	input  logic [emb_pkg::PIX_W-1:0] sample,
	input  logic [emb_pkg::PIX_W-1:0] upper,
	input  logic [emb_pkg::PIX_W-1:0] middle,
	input  logic [emb_pkg::ROW_W-1:0] row,
	input  logic [emb_pkg::COL_W-1:0] col,
	input  logic [emb_pkg::CH_W-1:0]  ch,
	input  emb_pkg::geom_t            geom,
	output emb_pkg::res_push_t        push
);
	import emb_pkg::*;

	// column x-2: up2/mid2, column x-1: up1/mid1/low1
	logic [PIX_W-1:0] up2_q  [MAX_CHANNELS];
	logic [PIX_W-1:0] mid2_q [MAX_CHANNELS];
	logic [PIX_W-1:0] up1_q  [MAX_CHANNELS];
	logic [PIX_W-1:0] mid1_q [MAX_CHANNELS];
	logic [PIX_W-1:0] low1_q [MAX_CHANNELS];

	logic signed [11:0] sum;
	logic [PIX_W-1:0]   filt;
	logic [PIX_W-1:0]   val0;
	logic               interior;
	logic [MAX_RESULTS-1:0] en;
	res_t [MAX_RESULTS-1:0] item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				up2_q[i]  <= '0;
				mid2_q[i] <= '0;
				up1_q[i]  <= '0;
				mid1_q[i] <= '0;
				low1_q[i] <= '0;
			end
		end else if (upd) begin
			up2_q[ch]  <= up1_q[ch];
			mid2_q[ch] <= mid1_q[ch];
			up1_q[ch]  <= upper;
			mid1_q[ch] <= middle;
			low1_q[ch] <= sample;
		end
	end

	always_comb begin
		sum = $signed({3'b000, sample, 1'b0}) + $signed({4'b0000, middle})
			+ $signed({4'b0000, low1_q[ch]}) + $signed({4'b0000, mid1_q[ch]})
			- $signed({3'b000, up2_q[ch], 1'b0}) - $signed({4'b0000, up1_q[ch]})
			- $signed({4'b0000, mid2_q[ch]});
		if (sum < 0) begin
			filt = '0;
		end else if (sum > 12'sd255) begin
			filt = '1;
		end else begin
			filt = sum[PIX_W-1:0];
		end
	end

	always_comb begin
		interior = (row >= ROW_W'(2)) && (col >= COL_W'(2));
		val0     = interior ? filt : mid1_q[ch];

		en[0] = (row != '0) && (col != '0);
		en[1] = (row != '0) && ({1'b0, col} == geom.w - DIM_W'(1));
		en[2] = ({1'b0, row} == geom.h - DIM_W'(1));

		item[0].pixel_value = val0;
		item[0].out_row     = row - ROW_W'(1);
		item[0].out_column  = col - COL_W'(1);
		item[1].pixel_value = middle;
		item[1].out_row     = row - ROW_W'(1);
		item[1].out_column  = col;
		item[2].pixel_value = sample;
		item[2].out_row     = row;
		item[2].out_column  = col;

		for (int k = 0; k < MAX_RESULTS; k++) begin
			item[k].out_channel  = ch;
			item[k].end_of_frame = is_eof(item[k].out_row, item[k].out_column, ch, geom);
		end
		item[2].last_of_run = en[2];
		item[1].last_of_run = en[1] && !en[2];
		item[0].last_of_run = en[0] && !en[1] && !en[2];

		push.valid = en;
		push.item  = item;
	end
endmodule

// ===== hw/rtl/emb_res_fifo.sv =====
// ----------------------------------------------------------------------------
// emb_res_fifo
// Result queue: takes up to three results in one cycle, hands out one per
// request on the result channel.
// ----------------------------------------------------------------------------
module emb_res_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_en,
	input  emb_pkg::res_push_t push,
	output logic               space_ok,
	emb_out_if.source          res_ch
);
	import emb_pkg::*;

	localparam int AW  = $clog2(RES_FIFO_DEPTH);
	localparam int CNT_W = $clog2(RES_FIFO_DEPTH + 1);

	res_t             mem_q [RES_FIFO_DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic [AW-1:0]    off [MAX_RESULTS];
	logic [CNT_W-1:0] n_push;
	logic             pop;
	res_t             head;

	always_comb begin
		n_push = '0;
		for (int k = 0; k < MAX_RESULTS; k++) begin
			off[k] = n_push[AW-1:0];
			if (push_en && push.valid[k]) begin
				n_push = n_push + CNT_W'(1);
			end
		end
	end

	assign pop      = res_ch.valid && res_ch.ready;
	assign space_ok = (count_q <= CNT_W'(RES_FIFO_DEPTH - MAX_RESULTS));

	always_ff @(posedge clk) begin
		if (push_en) begin
			for (int k = 0; k < MAX_RESULTS; k++) begin
				if (push.valid[k]) begin
					mem_q[wr_ptr_q + off[k]] <= push.item[k];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + n_push[AW-1:0];
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			count_q <= count_q + n_push - CNT_W'(pop);
		end
	end

	assign head                = mem_q[rd_ptr_q];
	assign res_ch.valid        = (count_q != '0);
	assign res_ch.pixel_value  = head.pixel_value;
	assign res_ch.out_row      = head.out_row;
	assign res_ch.out_column   = head.out_column;
	assign res_ch.out_channel  = head.out_channel;
	assign res_ch.last_of_run  = head.last_of_run;
	assign res_ch.end_of_frame = head.end_of_frame;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(RES_FIFO_DEPTH))
		else $error("result queue count beyond depth");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push_en && (push.valid != '0)) |-> space_ok)
		else $error("results pushed without room");
	a_one_last: assert property (@(posedge clk) disable iff (!arst_n)
		(push_en && (push.valid != '0)) |->
		($countones(push.valid & {push.item[2].last_of_run, push.item[1].last_of_run,
			push.item[0].last_of_run}) == 1))
		else $error("run of results without exactly one last flag");
`endif
endmodule

// ===== hw/rtl/emboss_3x3_clamp_filter.sv =====
// ----------------------------------------------------------------------------
// emboss_3x3_clamp_filter
// Streaming 3x3 emboss filter with clamp, border copy and position tags.
// ----------------------------------------------------------------------------
// One sample is accepted per cycle while stage 1 is empty or the result
// queue has room. It is registered with its line buffer read (one 8192 x 16
// RAM holding both rows above, read and written once per sample), then
// filtered and queued; results leave one per cycle while the sink is ready.
// Samples in the right column and the last row produce up to three results,
// so there the single result port sets the rate and the eight-entry result
// queue holds off input once nearly full. Line buffers need no clearing pass.
// ----------------------------------------------------------------------------
module emboss_3x3_clamp_filter (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [1:0]               cfg_index,
	input  logic [emb_pkg::CFG_W-1:0] cfg_data,
	emb_in_if.sink                   in_ch,
	emb_out_if.source                res_ch
);
	import emb_pkg::*;

	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic [NCH_W-1:0] chans_q;
	geom_t            geom;

	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic [CH_W-1:0]  ch_q;
	logic [DIM_W-1:0] col_inc;
	logic [DIM_W-1:0] row_inc;
	logic [NCH_W-1:0] ch_inc;

	logic             valid_s1;
	logic [PIX_W-1:0] sample_s1;
	logic [ROW_W-1:0] row_s1;
	logic [COL_W-1:0] col_s1;
	logic [CH_W-1:0]  ch_s1;
	logic [LINE_W-1:0] line_rd;

	logic       accept;
	logic       s1_adv;
	logic       space_ok;
	res_push_t  push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			chans_q  <= CHANNELS_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_WIDTH:    width_q  <= cfg_data;
				CFG_HEIGHT:   height_q <= cfg_data;
				CFG_CHANNELS: chans_q  <= cfg_data[NCH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q == '0) begin
			geom.w = DIM_W'(1);
		end else if (width_q > DIM_W'(MAX_WIDTH)) begin
			geom.w = DIM_W'(MAX_WIDTH);
		end else begin
			geom.w = width_q;
		end
		if (height_q == '0) begin
			geom.h = DIM_W'(1);
		end else if (height_q > DIM_W'(MAX_HEIGHT)) begin
			geom.h = DIM_W'(MAX_HEIGHT);
		end else begin
			geom.h = height_q;
		end
		if (chans_q == '0) begin
			geom.nc = NCH_W'(1);
		end else if (chans_q > NCH_W'(MAX_CHANNELS)) begin
			geom.nc = NCH_W'(MAX_CHANNELS);
		end else begin
			geom.nc = chans_q;
		end
	end

	assign s1_adv       = valid_s1 && space_ok;
	assign in_ch.ready  = !valid_s1 || s1_adv;
	assign accept       = in_ch.valid && in_ch.ready;

	assign col_inc = {1'b0, col_q} + DIM_W'(1);
	assign row_inc = {1'b0, row_q} + DIM_W'(1);
	assign ch_inc  = {1'b0, ch_q} + NCH_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			ch_q  <= '0;
		end else if (accept) begin
			if (ch_inc >= geom.nc) begin
				ch_q <= '0;
				if (col_inc >= geom.w) begin
					col_q <= '0;
					row_q <= (row_inc >= geom.h) ? '0 : row_inc[ROW_W-1:0];
				end else begin
					col_q <= col_inc[COL_W-1:0];
				end
			end else begin
				ch_q <= ch_inc[CH_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= in_ch.sample;
			row_s1    <= row_q;
			col_s1    <= col_q;
			ch_s1     <= ch_q;
		end
	end

	emb_line_ram #(
		.WIDTH (LINE_W),
		.DEPTH (LINE_DEPTH)
	) u_line_ram (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr ({col_q, ch_q}),
		.rd_data (line_rd),
		.wr_en   (s1_adv),
		.wr_addr ({col_s1, ch_s1}),
		.wr_data ({line_rd[PIX_W-1:0], sample_s1})
	);

	emb_window u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (s1_adv),
		.sample (sample_s1),
		.upper  (line_rd[LINE_W-1:PIX_W]),
		.middle (line_rd[PIX_W-1:0]),
		.row    (row_s1),
		.col    (col_s1),
		.ch     (ch_s1),
		.geom   (geom),
		.push   (push)
	);

	emb_res_fifo u_res_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_en  (s1_adv),
		.push     (push),
		.space_ok (space_ok),
		.res_ch   (res_ch)
	);

`ifndef SYNTHESIS
	a_accept_frees_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && valid_s1) |-> s1_adv)
		else $error("request taken while stage 1 holds");
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_adv) |=> (valid_s1 && $stable(sample_s1) && $stable(col_s1)))
		else $error("stalled stage 1 changed");
	a_s1_load: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted request did not reach stage 1");
`endif
endmodule
